// ===== rtl/vovt_pkg.sv =====
// Shared types, constants and helpers for the vertex outcode and viewport transform.
`timescale 1ns / 1ps
package vovt_pkg;

  // Default number of fraction bits in all fixed-point values.
  localparam int unsigned FracBitsDef = 16;

  // Quotient bits produced by the divider; larger quotients clamp to 2^QuoBits.
  localparam int unsigned QuoBits = 40;
  // Width of the divider numerator (46-bit product shifted by up to 24 bits).
  localparam int unsigned NumW = 70;
  // Width of the divisor 2*|w| and of the partial remainder.
  localparam int unsigned DivW = 34;
  // Width of the signed quotient and of the final sum.
  localparam int unsigned SQuoW = QuoBits + 2;
  localparam int unsigned SumW = QuoBits + 4;

  // Configuration register indexes.
  typedef enum logic [2:0] {
    CfgOriginX = 3'd0,
    CfgOriginY = 3'd1,
    CfgWidth   = 3'd2,
    CfgHeight  = 3'd3,
    CfgNear    = 3'd4,
    CfgFar     = 3'd5
  } cfg_idx_e;

  // State of one divider lane between two steps.
  typedef struct packed {
    logic [DivW-1:0]    rem;
    logic [QuoBits-1:0] nlo;
    logic [QuoBits-1:0] quo;
    logic               ovf;
  } lane_t;

  // Per-vertex control that travels beside the divider lanes.
  typedef struct packed {
    logic [DivW-1:0] dvs;
    logic            negx;
    logic            negy;
    logic            negz;
    logic [5:0]      outcode;
    logic            wz;
  } side_t;

  // Saturate a wide signed sum to the signed 32-bit range.
  function automatic logic [31:0] sat32(input logic signed [SumW-1:0] v);
    logic signed [SumW-1:0] hi;
    logic signed [SumW-1:0] lo;
    hi = SumW'(32'sh7fffffff);
    lo = -SumW'(33'sh80000000);
    if (v > hi) begin
      return 32'h7fffffff;
    end else if (v < lo) begin
      return 32'h80000000;
    end else begin
      return v[31:0];
    end
  endfunction

endpackage

// ===== rtl/vovt_div_step.sv =====
// One restoring-division step of a pipelined divider lane: one quotient bit per stage.
`timescale 1ns / 1ps
module vovt_div_step (
  input  logic                          clk_i,
  input  logic                          en_i,
  input  logic [vovt_pkg::DivW-1:0]     dvs_i,
  input  vovt_pkg::lane_t               lane_i,
  output vovt_pkg::lane_t               lane_o
);
  import vovt_pkg::*;

  logic [DivW-1:0] trial;
  logic            ge;
  lane_t           lane_d;
  lane_t           lane_q;

  // Shift in the next numerator bit and subtract the divisor when it fits.
  always_comb begin
    trial         = {lane_i.rem[DivW-2:0], lane_i.nlo[QuoBits-1]};
    ge            = (trial >= dvs_i);
    lane_d.rem    = ge ? (trial - dvs_i) : trial;
    lane_d.nlo    = {lane_i.nlo[QuoBits-2:0], 1'b0};
    lane_d.quo    = {lane_i.quo[QuoBits-2:0], ge};
    lane_d.ovf    = lane_i.ovf;
  end

  // Stage register, loaded whenever the stage advances.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      lane_q <= lane_d;
    end
  end

  assign lane_o = lane_q;

endmodule

// ===== rtl/vertex_outcode_viewport_transform.sv =====
// Top level: clip outcode, perspective divide and viewport/depth mapping pipeline.
`timescale 1ns / 1ps
// Accepts one clip-space vertex per cycle while not stalled and returns one result per
// vertex, in order. The pipeline has three lanes (x, y, depth) of a 40-stage
// restoring divider that settles one quotient bit per stage, preceded by input,
// multiply and divider-setup stages and followed by a sign stage and the output register,
// 45 register stages in all. Each stage holds its item while the stage after it is full
// and stalled, so bubbles are squeezed out and a stall at the output reaches the input
// only once every stage is occupied. Configuration writes take effect at once and must be
// made while no vertex is in flight.
module vertex_outcode_viewport_transform #(
  parameter int unsigned FRAC_BITS = vovt_pkg::FracBitsDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Configuration write port.
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [31:0] cfg_data_i,
  // Vertex input channel.
  input  logic        valid_i,
  output logic        stall_o,
  input  logic [31:0] clip_x_i,
  input  logic [31:0] clip_y_i,
  input  logic [31:0] clip_z_i,
  input  logic [31:0] clip_w_i,
  // Result channel.
  output logic        valid_o,
  input  logic        stall_i,
  output logic [31:0] screen_x_o,
  output logic [31:0] screen_y_o,
  output logic [31:0] depth_value_o,
  output logic [5:0]  outcode_o,
  output logic        w_zero_o
);
  import vovt_pkg::*;

  localparam int unsigned NumStages = QuoBits + 5;
  localparam int unsigned StgInit   = 2;
  localparam int unsigned StgSign   = QuoBits + 3;
  localparam int unsigned StgOut    = QuoBits + 4;

  // Configuration registers.
  logic signed [13:0] origin_x_q, origin_y_q;
  logic [13:0]        width_q, height_q;
  logic signed [31:0] near_q, far_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      origin_x_q <= '0;
      origin_y_q <= '0;
      width_q    <= '0;
      height_q   <= '0;
      near_q     <= 32'sd65536;
      far_q      <= 32'sd6553600;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgOriginX: origin_x_q <= cfg_data_i[13:0];
        CfgOriginY: origin_y_q <= cfg_data_i[13:0];
        CfgWidth:   width_q    <= cfg_data_i[13:0];
        CfgHeight:  height_q   <= cfg_data_i[13:0];
        CfgNear:    near_q     <= cfg_data_i;
        CfgFar:     far_q      <= cfg_data_i;
        default:    ;
      endcase
    end
  end

  // Pipeline occupancy and advance chain.
  logic [NumStages-1:0] vld_q;
  logic [NumStages:0]   adv;

  always_comb begin
    adv[NumStages] = !stall_i;
    for (int k = NumStages - 1; k >= 0; k--) begin
      adv[k] = !vld_q[k] || adv[k+1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (adv[0]) begin
        vld_q[0] <= valid_i;
      end
      for (int k = 1; k < NumStages; k++) begin
        if (adv[k]) begin
          vld_q[k] <= vld_q[k-1];
        end
      end
    end
  end

  assign stall_o = !adv[0];
  assign valid_o = vld_q[StgOut];

  // Side information travels with each stage up to the sign stage.
  side_t side_q [StgOut];
  side_t side0_d;
  side_t side1_d;

  // Stage 0: magnitudes, signs, divisor and outcode.
  logic signed [32:0] ext_x, ext_y, ext_z, ext_w;
  logic signed [32:0] w_m_x, x_p_w, w_m_y, y_p_w, w_m_z, z_p_w;
  logic [31:0]        ax_d, ay_d, az_d, aw_d;
  logic [31:0]        ax_q, ay_q, az_q;
  logic               sx, sy, sz, sw;

  always_comb begin
    ext_x = {clip_x_i[31], clip_x_i};
    ext_y = {clip_y_i[31], clip_y_i};
    ext_z = {clip_z_i[31], clip_z_i};
    ext_w = {clip_w_i[31], clip_w_i};
    w_m_x = ext_w - ext_x;
    x_p_w = ext_x + ext_w;
    w_m_y = ext_w - ext_y;
    y_p_w = ext_y + ext_w;
    w_m_z = ext_w - ext_z;
    z_p_w = ext_z + ext_w;
    sx = clip_x_i[31];
    sy = clip_y_i[31];
    sz = clip_z_i[31];
    sw = clip_w_i[31];
    ax_d = sx ? (32'd0 - clip_x_i) : clip_x_i;
    ay_d = sy ? (32'd0 - clip_y_i) : clip_y_i;
    az_d = sz ? (32'd0 - clip_z_i) : clip_z_i;
    aw_d = sw ? (32'd0 - clip_w_i) : clip_w_i;
    side0_d.dvs     = {1'b0, aw_d, 1'b0};
    side0_d.negx    = sx ^ sw;
    side0_d.negy    = sy ^ sw;
    side0_d.negz    = sz ^ sw;
    side0_d.outcode = {z_p_w[32], w_m_z[32], y_p_w[32], w_m_y[32], x_p_w[32], w_m_x[32]};
    side0_d.wz      = (clip_w_i == 32'd0);
  end

  // Stage 1: products of viewport size or depth span with the coordinate magnitudes.
  logic signed [32:0] span;
  logic [32:0]        span_mag;
  logic [64:0]        pz_full;
  logic [45:0]        px_q, py_q;
  logic [63:0]        pz_q;

  always_comb begin
    span     = {far_q[31], far_q} - {near_q[31], near_q};
    span_mag = span[32] ? (33'd0 - span) : span;
    pz_full  = span_mag * {1'b0, az_q};
    side1_d      = side_q[0];
    side1_d.negz = side_q[0].negz ^ span[32];
  end

  // Stage 2: numerators, overflow check and divider lane setup.
  logic [NumW-1:0] nx, ny, nz;
  lane_t           init_x, init_y, init_z;

  function automatic lane_t lane_init(input logic [NumW-1:0] num, input logic [DivW-1:0] dvs);
    lane_t l;
    logic [DivW-1:0] hi;
    hi    = DivW'(num[NumW-1:QuoBits]);
    l.ovf = (hi >= dvs);
    l.rem = l.ovf ? '0 : hi;
    l.nlo = num[QuoBits-1:0];
    l.quo = '0;
    return l;
  endfunction

  always_comb begin
    nx = NumW'(px_q) << FRAC_BITS;
    ny = NumW'(py_q) << FRAC_BITS;
    nz = NumW'(pz_q);
    init_x = lane_init(nx, side_q[1].dvs);
    init_y = lane_init(ny, side_q[1].dvs);
    init_z = lane_init(nz, side_q[1].dvs);
  end

  lane_t lx [QuoBits+1];
  lane_t ly [QuoBits+1];
  lane_t lz [QuoBits+1];

  // Stage registers ahead of the divider and the side chain.
  always_ff @(posedge clk_i) begin
    if (adv[0]) begin
      ax_q      <= ax_d;
      ay_q      <= ay_d;
      az_q      <= az_d;
      side_q[0] <= side0_d;
    end
    if (adv[1]) begin
      px_q      <= width_q * ax_q;
      py_q      <= height_q * ay_q;
      pz_q      <= pz_full[63:0];
      side_q[1] <= side1_d;
    end
    if (adv[StgInit]) begin
      lx[0] <= init_x;
      ly[0] <= init_y;
      lz[0] <= init_z;
    end
    for (int k = StgInit; k < StgOut; k++) begin
      if (adv[k]) begin
        side_q[k] <= side_q[k-1];
      end
    end
  end

  // Divider steps, one quotient bit per stage for each lane.
  for (genvar j = 0; j < QuoBits; j++) begin : g_div
    vovt_div_step u_step_x (
      .clk_i  (clk_i),
      .en_i   (adv[StgInit+1+j]),
      .dvs_i  (side_q[StgInit+j].dvs),
      .lane_i (lx[j]),
      .lane_o (lx[j+1])
    );
    vovt_div_step u_step_y (
      .clk_i  (clk_i),
      .en_i   (adv[StgInit+1+j]),
      .dvs_i  (side_q[StgInit+j].dvs),
      .lane_i (ly[j]),
      .lane_o (ly[j+1])
    );
    vovt_div_step u_step_z (
      .clk_i  (clk_i),
      .en_i   (adv[StgInit+1+j]),
      .dvs_i  (side_q[StgInit+j].dvs),
      .lane_i (lz[j]),
      .lane_o (lz[j+1])
    );
  end

  // Sign stage: clamp the quotient and apply the sign.
  function automatic logic signed [SQuoW-1:0] signed_quo(input lane_t l, input logic neg);
    logic [SQuoW-1:0] mag;
    mag = l.ovf ? (SQuoW'(1) << QuoBits) : SQuoW'(l.quo);
    return neg ? $signed(SQuoW'(0) - mag) : $signed(mag);
  endfunction

  logic signed [SQuoW-1:0] qx_q, qy_q, qz_q;

  always_ff @(posedge clk_i) begin
    if (adv[StgSign]) begin
      qx_q <= signed_quo(lx[QuoBits], side_q[StgSign-1].negx);
      qy_q <= signed_quo(ly[QuoBits], side_q[StgSign-1].negy);
      qz_q <= signed_quo(lz[QuoBits], side_q[StgSign-1].negz);
    end
  end

  // Output stage: add the viewport center or depth midpoint and saturate, or give zero when w is zero.
  logic signed [15:0]     cx_base, cy_base;
  logic signed [SumW-1:0] off_x, off_y, off_z;
  logic signed [32:0]     nf_sum, nf_adj, nf_half;
  logic signed [SumW-1:0] sum_x, sum_y, sum_z;

  always_comb begin
    cx_base = $signed({origin_x_q[13], origin_x_q, 1'b0}) + $signed({2'b00, width_q});
    cy_base = $signed({origin_y_q[13], origin_y_q, 1'b0}) + $signed({2'b00, height_q});
    off_x   = $signed({{(SumW-16){cx_base[15]}}, cx_base}) <<< (FRAC_BITS - 1);
    off_y   = $signed({{(SumW-16){cy_base[15]}}, cy_base}) <<< (FRAC_BITS - 1);
    nf_sum  = $signed({near_q[31], near_q}) + $signed({far_q[31], far_q});
    nf_adj  = nf_sum + $signed({32'd0, nf_sum[32]});
    nf_half = nf_adj >>> 1;
    off_z   = $signed({{(SumW-33){nf_half[32]}}, nf_half});
    sum_x   = $signed({{(SumW-SQuoW){qx_q[SQuoW-1]}}, qx_q}) + off_x;
    sum_y   = $signed({{(SumW-SQuoW){qy_q[SQuoW-1]}}, qy_q}) + off_y;
    sum_z   = $signed({{(SumW-SQuoW){qz_q[SQuoW-1]}}, qz_q}) + off_z;
  end

  logic [31:0] screen_x_q, screen_y_q, depth_q;
  logic [5:0]  outcode_q;
  logic        wz_q;

  always_ff @(posedge clk_i) begin
    if (adv[StgOut]) begin
      wz_q       <= side_q[StgSign].wz;
      outcode_q  <= side_q[StgSign].outcode;
      screen_x_q <= side_q[StgSign].wz ? 32'd0 : sat32(sum_x);
      screen_y_q <= side_q[StgSign].wz ? 32'd0 : sat32(sum_y);
      depth_q    <= side_q[StgSign].wz ? 32'd0 : sat32(sum_z);
    end
  end

  assign screen_x_o    = screen_x_q;
  assign screen_y_o    = screen_y_q;
  assign depth_value_o = depth_q;
  assign outcode_o     = outcode_q;
  assign w_zero_o      = wz_q;

  // A zero w forces all coordinate results to zero.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && w_zero_o |-> screen_x_o == 32'd0 && screen_y_o == 32'd0
                            && depth_value_o == 32'd0)
    else $error("zero w result carries nonzero coordinates");

  // With w zero, x cannot lie both beyond +w and below -w.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && w_zero_o |-> !(outcode_o[0] && outcode_o[1]))
    else $error("outcode flags both x planes for zero w");

  // The input is held back only when the first stage is occupied.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    stall_o |-> vld_q[0])
    else $error("input stalled with an empty first stage");

  // An unstalled output always drains, so its stage is free next cycle or refilled.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && !stall_i && !vld_q[StgOut-1] |=> !valid_o)
    else $error("delivered result repeated at the output");

endmodule
